>>> hdl/hag_pkg.sv
package hag_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 256;
	localparam int unsigned DIGEST_W = 256;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [PADDR_W-1:0] ADDR_ENFORCE = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_RUNNING = 3'd4;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_REMOVE = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_KNOWN       = 4'd0,
		ST_ENROLLED    = 4'd1,
		ST_ENROLL_FULL = 4'd2,
		ST_DENIED      = 4'd3,
		ST_UNHASHED_OK = 4'd4,
		ST_ADD_OK      = 4'd5,
		ST_ADD_FULL    = 4'd6,
		ST_REMOVED     = 4'd7,
		ST_NOT_FOUND   = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_COMMIT
	} fsm_t;

	typedef struct packed {
		logic [1:0]  action;
		logic        digest_ok;
		logic [63:0] digest_w0;
		logic [63:0] digest_w1;
		logic [63:0] digest_w2;
		logic [63:0] digest_w3;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        allowed;
		logic [8:0]  entries_held;
		logic [31:0] denials;
	} rsp_t;

	typedef struct packed {
		logic enforce;
		logic running;
	} cfg_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic res_free;
	} sts_t;

endpackage

>>> hdl/hag_regs.sv
module hag_regs import hag_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic enforce_q;
	logic running_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q <= 1'b0;
			running_q <= 1'b0;
		end else if (wr) begin
			if (paddr == ADDR_ENFORCE) enforce_q <= pwdata[0];
			if (paddr == ADDR_RUNNING) running_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_ENFORCE) prdata[0] = enforce_q;
		else if (paddr == ADDR_RUNNING) prdata[0] = running_q;
	end

	assign cfg.enforce = enforce_q;
	assign cfg.running = running_q;

endmodule

>>> hdl/hag_ctrl.sv
module hag_ctrl import hag_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	fsm_t state_q;
	fsm_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_stall = 1'b1;
		unique case (state_q)
			FSM_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.last) state_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.last) state_d = FSM_DRAIN;
			end
			// last row is compared during this cycle
			FSM_DRAIN: begin
				state_d = FSM_COMMIT;
			end
			FSM_COMMIT: begin
				// hold until the result register is free
				if (sts.res_free) begin
					cmd.commit = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_CLEAR;
			end
		endcase
	end

endmodule

>>> hdl/hag_datapath.sv
module hag_datapath import hag_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cfg_t cfg,
	input  cmd_t cmd,
	output sts_t sts,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(MAX_ENTRIES - 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

	// one row per slot: valid bit on top of the digest
	logic [DIGEST_W:0]   store_q [MAX_ENTRIES];
	logic [DIGEST_W:0]   rd_row_s1;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;

	req_t                req_q;
	logic [IW-1:0]       idx_q;
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic                free_q;
	logic [IW-1:0]       free_idx_q;
	logic [CW-1:0]       cnt_q;
	logic [31:0]         den_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [DIGEST_W-1:0] digest;
	logic                enforcing;
	logic                full;
	logic                deny;
	status_t             status_d;
	logic                allowed_d;
	logic [CW-1:0]       cnt_d;
	logic [31:0]         den_d;
	logic                wr_c;
	logic [IW-1:0]       wr_addr_c;
	logic [DIGEST_W:0]   wr_row_c;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [DIGEST_W:0]   wr_row;

	assign digest = {req_q.digest_w3, req_q.digest_w2, req_q.digest_w1, req_q.digest_w0};
	assign enforcing = cfg.enforce & cfg.running;
	assign full = (cnt_q >= CNT_MAX);

	assign sts.last = (idx_q == IDX_LAST);
	assign sts.res_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.take) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.take) begin
			idx_q <= '0;
		end else if (cmd.clr || cmd.rd) begin
			idx_q <= sts.last ? '0 : idx_q + IW'(1);
		end
	end

	// row store
	always_ff @(posedge clk) begin
		if (wr_en) store_q[wr_addr] <= wr_row;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_row_s1 <= store_q[idx_q];
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
		end
	end

	// track first match and lowest free slot while the scan runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.take) begin
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_row_s1[DIGEST_W] && (rd_row_s1[DIGEST_W-1:0] == digest) && !hit_q)
				hit_q <= 1'b1;
			if (!rd_row_s1[DIGEST_W] && !free_q)
				free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_row_s1[DIGEST_W] && (rd_row_s1[DIGEST_W-1:0] == digest) && !hit_q)
				hit_idx_q <= rd_idx_s1;
			if (!rd_row_s1[DIGEST_W] && !free_q)
				free_idx_q <= rd_idx_s1;
		end
	end

	always_comb begin
		status_d = ST_NOT_FOUND;
		allowed_d = 1'b0;
		cnt_d = cnt_q;
		den_d = den_q;
		deny = 1'b0;
		wr_c = 1'b0;
		wr_addr_c = free_idx_q;
		wr_row_c = {1'b1, digest};
		unique case (req_q.action)
			ACT_LOAD: begin
				if (!req_q.digest_ok) begin
					if (enforcing) begin
						deny = 1'b1;
					end else begin
						status_d = ST_UNHASHED_OK;
						allowed_d = 1'b1;
					end
				end else if (hit_q) begin
					status_d = ST_KNOWN;
					allowed_d = 1'b1;
				end else if (!enforcing) begin
					allowed_d = 1'b1;
					if (full) begin
						status_d = ST_ENROLL_FULL;
					end else begin
						status_d = ST_ENROLLED;
						wr_c = 1'b1;
						cnt_d = cnt_q + CW'(1);
					end
				end else begin
					deny = 1'b1;
				end
			end
			ACT_ADD: begin
				if (hit_q) begin
					status_d = ST_ADD_OK;
				end else if (full) begin
					status_d = ST_ADD_FULL;
				end else begin
					status_d = ST_ADD_OK;
					wr_c = 1'b1;
					cnt_d = cnt_q + CW'(1);
				end
			end
			ACT_REMOVE: begin
				if (hit_q) begin
					status_d = ST_REMOVED;
					wr_c = 1'b1;
					wr_addr_c = hit_idx_q;
					wr_row_c = {1'b0, digest};
					if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (deny) begin
			status_d = ST_DENIED;
			if (den_q != '1) den_d = den_q + 32'd1;
		end
	end

	assign wr_en = cmd.clr || (cmd.commit && wr_c);
	assign wr_addr = cmd.clr ? idx_q : wr_addr_c;
	assign wr_row = cmd.clr ? '0 : wr_row_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			den_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				cnt_q <= cnt_d;
				den_q <= den_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status <= status_d;
			rsp_q.allowed <= allowed_d;
			rsp_q.entries_held <= 9'(cnt_d);
			rsp_q.denials <= den_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || !rsp_stall))
		else $error("commit over a pending result");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count beyond capacity");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && wr_c && req_q.action != ACT_REMOVE) |-> free_q)
		else $error("enroll without a free slot");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(cnt_q) && $stable(den_q))
		else $error("counters moved outside commit");

endmodule

>>> hdl/hash_allowlist_gate_top.sv
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_stall     req_t   action, digest_ok, digest_w0..w3
// rsp       out        rsp_valid / rsp_stall     rsp_t   status, allowed, entries_held, denials
// apb       in         psel/penable/pwrite/pready enforce at 0x0, running at 0x4
//
// After reset a clearing pass writes every store row, with req stalled.
// A request runs through accept, one row read per cycle over the
// single-port row store, a compare drain step and a commit step.
// The result sits in an output register; the next request is accepted while it waits,
// and only the commit of that next request holds while rsp_stall is high.
module hash_allowlist_gate_top import hag_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	hag_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	hag_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
